[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the hue key block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define HHG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define HHG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hhg_pkg.sv]
// Types and constants of the HLS hue key to gray block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package hhg_pkg;

  localparam int unsigned PixW    = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW    = 9;
  localparam int unsigned QuoW    = 8;
  localparam int unsigned SatNumW = 16;
  localparam int unsigned SatDenW = 9;
  localparam int unsigned DltNumW = 14;
  localparam int unsigned DltDenW = 8;
  localparam int unsigned HueRawW = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHueLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHueHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSatMin  = 2'd2;

  localparam logic [ChanW-1:0] HueLowRst  = 8'd145;
  localparam logic [ChanW-1:0] HueHighRst = 8'd175;
  localparam logic [ChanW-1:0] SatMinRst  = 8'd100;

  localparam logic [ChanW-1:0] ChanMax       = 8'd255;
  localparam logic [ChanW-1:0] HueDeltaScale = 8'd42;
  localparam logic [ChanW-1:0] HueWrap       = 8'd255;
  localparam logic [HueRawW-1:0] HueGreenBase = 10'd85;
  localparam logic [HueRawW-1:0] HueBlueBase  = 10'd170;

  // Lightness is at most half range exactly when max + min is at most 254.
  localparam logic [SumW-1:0] SumLowMax = 9'd254;
  localparam logic [SumW-1:0] SumFull   = 9'd510;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

  typedef struct packed {
    logic [PixW-1:0] px;
    logic            achro;
    max_sel_e        sel;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/hhg_div.sv]
// Pipelined restoring divider for the hue key block, Step quotient bits per stage.
// No dependencies. The quotient must fit in QuoW bits.
`default_nettype none

module hhg_div #(
  parameter int unsigned NumW = 16,
  parameter int unsigned DenW = 9,
  parameter int unsigned QuoW = 8,
  parameter int unsigned Step = 2,
  localparam int unsigned Stages = (QuoW + Step - 1) / Step
) (
  input  logic              clk_i,
  input  logic [Stages-1:0] en_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  output logic [QuoW-1:0]   quo_o
);

  localparam int unsigned ExtW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  // The last stage keeps only its quotient.
  logic [NumW-1:0] rem_q [Stages-1];
  logic [DenW-1:0] den_q [Stages-1];
  logic [QuoW-1:0] quo_q [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [NumW-1:0] rem_nxt;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [QuoW-1:0] quo_nxt;
    logic [ExtW-1:0] trial;

    if (k == 0) begin : g_head
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int j = 0; j < Step; j++) begin
        if (k * Step + j < QuoW) begin
          trial = ExtW'(den_in) << (QuoW - 1 - k * Step - j);
          if (ExtW'(rem_nxt) >= trial) begin
            rem_nxt = rem_nxt - trial[NumW-1:0];
            quo_nxt[QuoW-1-k*Step-j] = 1'b1;
          end
        end
      end
    end

    if (k < Stages - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= rem_nxt;
          den_q[k] <= den_in;
          quo_q[k] <= quo_nxt;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          quo_q[k] <= quo_nxt;
        end
      end
    end
  end

  assign quo_o = quo_q[Stages-1];

endmodule

`default_nettype wire

[hw/rtl/hls_hue_key_to_gray.sv]
// Top level of the HLS hue key to gray block: pixel pipeline and key registers.
// Depends on hhg_pkg and hhg_div.
//
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    pixel_in_i[31:0]
// out      out  out_valid_o / out_stall_i  pixel_out_o[31:0], keyed_o
// cfg      in   cfg_we_i                   cfg_idx_i[1:0], cfg_data_i[7:0]
//
// One item per clock is taken and delivered in steady state while the output is not stalled.
// Registers: stage 0, stage 1, the divider stages and the output stage. The four
// restoring dividers resolve DivStep quotient bits per stage; DivStep runs from 1 to 4.
// Reset clears the stage valid bits and loads the key registers with their defaults.
// A stall on the output fills bubbles stage by stage before the input stalls.
`default_nettype none

module hls_hue_key_to_gray #(
  parameter int unsigned DivStep = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hhg_pkg::PixW-1:0]     pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hhg_pkg::PixW-1:0]     pixel_out_o,
  output logic                         keyed_o,
  input  logic                         cfg_we_i,
  input  logic [hhg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hhg_pkg::ChanW-1:0]    cfg_data_i
);

  import hhg_pkg::*;

  localparam int unsigned DivStages = (QuoW + DivStep - 1) / DivStep;
  localparam int unsigned DivFirst  = 2;
  localparam int unsigned NumStages = DivStages + 3;
  localparam int unsigned OutStage  = NumStages - 1;

  // Key window registers.
  logic [ChanW-1:0] hue_low_q, hue_high_q, sat_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HueLowRst;
      hue_high_q <= HueHighRst;
      sat_min_q  <= SatMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHueLow:  hue_low_q  <= cfg_data_i;
        RegHueHigh: hue_high_q <= cfg_data_i;
        RegSatMin:  sat_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it moves on.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  assign en[OutStage] = !vld_q[OutStage] || !out_stall_i;
  for (genvar i = 0; i < OutStage; i++) begin : g_en
    assign en[i] = !vld_q[i] || en[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[OutStage];

  // Stage 0: max, min and the channel that picks the hue formula.
  logic [ChanW-1:0] r_in, g_in, b_in, mx_rg, mn_rg, mx_d, mn_d;
  max_sel_e         sel_d;

  assign r_in  = pixel_in_i[23:16];
  assign g_in  = pixel_in_i[15:8];
  assign b_in  = pixel_in_i[7:0];
  assign mx_rg = (r_in >= g_in) ? r_in : g_in;
  assign mn_rg = (r_in <= g_in) ? r_in : g_in;
  assign mx_d  = (b_in > mx_rg) ? b_in : mx_rg;
  assign mn_d  = (b_in < mn_rg) ? b_in : mn_rg;

  always_comb begin
    if (r_in == mx_d) begin
      sel_d = SEL_RED;
    end else if (g_in == mx_d) begin
      sel_d = SEL_GREEN;
    end else begin
      sel_d = SEL_BLUE;
    end
  end

  logic [PixW-1:0]  s0_px_q;
  logic [ChanW-1:0] s0_mx_q, s0_mn_q;
  max_sel_e         s0_sel_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_px_q  <= pixel_in_i;
      s0_mx_q  <= mx_d;
      s0_mn_q  <= mn_d;
      s0_sel_q <= sel_d;
    end
  end

  // Stage 1: dividends and divisors for saturation and the channel deltas.
  logic [ChanW-1:0]   dif_d;
  logic [SumW-1:0]    sum_d, sat_den_d;
  logic [SatNumW-1:0] sat_num_d;
  logic [DltNumW-1:0] rd_num_d, gd_num_d, bd_num_d;
  side_t              side_d;

  assign dif_d     = s0_mx_q - s0_mn_q;
  assign sum_d     = SumW'(s0_mx_q) + SumW'(s0_mn_q);
  assign sat_den_d = (sum_d <= SumLowMax) ? sum_d : SumFull - sum_d;
  assign sat_num_d = SatNumW'(dif_d) * SatNumW'(ChanMax) + SatNumW'(sat_den_d >> 1);
  assign rd_num_d  = DltNumW'(s0_mx_q - s0_px_q[23:16]) * DltNumW'(HueDeltaScale)
                   + DltNumW'(dif_d >> 1);
  assign gd_num_d  = DltNumW'(s0_mx_q - s0_px_q[15:8]) * DltNumW'(HueDeltaScale)
                   + DltNumW'(dif_d >> 1);
  assign bd_num_d  = DltNumW'(s0_mx_q - s0_px_q[7:0]) * DltNumW'(HueDeltaScale)
                   + DltNumW'(dif_d >> 1);

  always_comb begin
    side_d.px    = s0_px_q;
    side_d.achro = (dif_d == '0);
    side_d.sel   = s0_sel_q;
  end

  side_t              s1_side_q;
  logic [SatNumW-1:0] s1_sat_num_q;
  logic [SatDenW-1:0] s1_sat_den_q;
  logic [DltNumW-1:0] s1_rd_num_q, s1_gd_num_q, s1_bd_num_q;
  logic [DltDenW-1:0] s1_dif_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_side_q    <= side_d;
      s1_sat_num_q <= sat_num_d;
      s1_sat_den_q <= sat_den_d;
      s1_rd_num_q  <= rd_num_d;
      s1_gd_num_q  <= gd_num_d;
      s1_bd_num_q  <= bd_num_d;
      s1_dif_q     <= dif_d;
    end
  end

  // Divider stages. Achromatic items carry a zero divisor; their quotients
  // are ignored because the achromatic flag blocks the key.
  logic [QuoW-1:0] sat_quo, rd_quo, gd_quo, bd_quo;

  hhg_div #(
    .NumW (SatNumW),
    .DenW (SatDenW),
    .QuoW (QuoW),
    .Step (DivStep)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (s1_sat_num_q),
    .den_i (s1_sat_den_q),
    .quo_o (sat_quo)
  );

  hhg_div #(
    .NumW (DltNumW),
    .DenW (DltDenW),
    .QuoW (QuoW),
    .Step (DivStep)
  ) u_rd_div (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (s1_rd_num_q),
    .den_i (s1_dif_q),
    .quo_o (rd_quo)
  );

  hhg_div #(
    .NumW (DltNumW),
    .DenW (DltDenW),
    .QuoW (QuoW),
    .Step (DivStep)
  ) u_gd_div (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (s1_gd_num_q),
    .den_i (s1_dif_q),
    .quo_o (gd_quo)
  );

  hhg_div #(
    .NumW (DltNumW),
    .DenW (DltDenW),
    .QuoW (QuoW),
    .Step (DivStep)
  ) u_bd_div (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (s1_bd_num_q),
    .den_i (s1_dif_q),
    .quo_o (bd_quo)
  );

  side_t dv_side_q [DivStages];

  always_ff @(posedge clk_i) begin
    if (en[DivFirst]) begin
      dv_side_q[0] <= s1_side_q;
    end
    for (int k = 1; k < DivStages; k++) begin
      if (en[DivFirst+k]) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // Last stage: hue, key decision and output pixel.
  side_t             hs;
  logic [HueRawW-1:0] hue_raw;
  logic [ChanW-1:0]   hue;
  logic               key_d;
  logic [PixW-1:0]    pix_d;

  assign hs = dv_side_q[DivStages-1];

  always_comb begin
    case (hs.sel)
      SEL_RED:   hue_raw = HueRawW'(bd_quo) - HueRawW'(gd_quo);
      SEL_GREEN: hue_raw = HueGreenBase + HueRawW'(rd_quo) - HueRawW'(bd_quo);
      default:   hue_raw = HueBlueBase + HueRawW'(gd_quo) - HueRawW'(rd_quo);
    endcase
  end

  // A negative hue shows as the top bit of the raw difference.
  assign hue   = hue_raw[HueRawW-1] ? hue_raw[ChanW-1:0] + HueWrap : hue_raw[ChanW-1:0];
  assign key_d = !hs.achro && (hue >= hue_low_q) && (hue <= hue_high_q)
              && (sat_quo > sat_min_q);
  assign pix_d = key_d ? {hs.px[31:24], hs.px[7:0], hs.px[7:0], hs.px[7:0]} : hs.px;

  logic [PixW-1:0] pix_out_q;
  logic            keyed_q;

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      pix_out_q <= pix_d;
      keyed_q   <= key_d;
    end
  end

  assign pixel_out_o = pix_out_q;
  assign keyed_o     = keyed_q;

endmodule

`default_nettype wire

[hw/rtl/hhg_checker.sv]
// Port-level checker for the HLS hue key to gray block, bound to its top level.
// Depends on hhg_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hhg_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic [hhg_pkg::PixW-1:0]     pixel_in_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [hhg_pkg::PixW-1:0]     pixel_out_o,
  input  logic                         keyed_o,
  input  logic                         cfg_we_i,
  input  logic [hhg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hhg_pkg::ChanW-1:0]    cfg_data_i
);

  import hhg_pkg::*;

  // A stalled result holds until it is taken.
  `HHG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o) && $stable(keyed_o), "stalled result changed")

  // A keyed item is gray.
  `HHG_ASSERT(a_keyed_gray, clk_i, rst_ni, out_valid_o && keyed_o |-> pixel_out_o[23:16] == pixel_out_o[7:0] && pixel_out_o[15:8] == pixel_out_o[7:0], "keyed item is not gray")

  // The input only stalls while the output holds a stalled result.
  `HHG_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o || !out_stall_i |-> !in_stall_o, "input stalled while output moves")

  // No result is offered while reset is held.
  `HHG_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind hls_hue_key_to_gray hhg_checker u_hhg_checker (.*);

`default_nettype wire
